// ===== design/ssqrt_pkg.sv =====
// Package for the signed integer square root block.
// Holds widths, the sequencer state type and the control/status structs.
// No dependencies.
package ssqrt_pkg;

  // Operand width that is used, and the resulting root iteration count
  localparam int unsigned OPERAND_BITS = 64;
  localparam int unsigned ITERS        = (OPERAND_BITS + 1) / 2;
  localparam int unsigned MAG_BITS     = 2 * ITERS;
  localparam int unsigned REM_BITS     = ITERS + 2;
  localparam int unsigned CNT_BITS     = $clog2(ITERS);

  // Port widths
  localparam int unsigned IN_TDATA_BITS  = 64;
  localparam int unsigned ROOT_BITS      = 33;
  localparam int unsigned OUT_TDATA_BITS = ((ROOT_BITS + 7) / 8) * 8;

  // Root sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Requests from the top level into the root unit
  typedef struct packed {
    logic start;  // load a new operand
    logic ack;    // finished root has been taken
  } core_ctrl_t;

  // Status from the root unit back to the top level
  typedef struct packed {
    logic idle;   // ready for a new operand
    logic done;   // root is valid and waiting
  } core_status_t;

endpackage

// ===== design/ssqrt_core.sv =====
// Iterative root unit: restoring digit-by-digit square root, one root bit a cycle.
// One shared subtract-and-compare serves every step. Depends on ssqrt_pkg.
module ssqrt_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ssqrt_pkg::core_ctrl_t                  ctrl,
  input  logic [ssqrt_pkg::IN_TDATA_BITS-1:0]    operand,
  output ssqrt_pkg::core_status_t                status,
  output logic [ssqrt_pkg::ROOT_BITS-1:0]        root
);

  ssqrt_pkg::state_t state, state_next;

  logic [ssqrt_pkg::CNT_BITS-1:0] count;
  logic [ssqrt_pkg::MAG_BITS-1:0] mag;
  logic [ssqrt_pkg::REM_BITS-1:0] rem;
  logic [ssqrt_pkg::ITERS-1:0]    res;
  logic                           neg;

  logic [ssqrt_pkg::OPERAND_BITS-1:0] op_raw;
  logic [ssqrt_pkg::OPERAND_BITS-1:0] op_mag;
  logic [ssqrt_pkg::REM_BITS-1:0]     rem_shift;
  logic [ssqrt_pkg::REM_BITS-1:0]     trial;
  logic [ssqrt_pkg::REM_BITS:0]       diff;
  logic [ssqrt_pkg::ROOT_BITS-1:0]    res_ext;

  // Magnitude of the used operand bits; the most negative value maps to 2^(w-1)
  assign op_raw = operand[ssqrt_pkg::OPERAND_BITS-1:0];
  assign op_mag = op_raw[ssqrt_pkg::OPERAND_BITS-1] ? (~op_raw + 1'b1) : op_raw;

  // Shared step: bring down two bits, try subtracting 4*root+1
  assign rem_shift = {rem[ssqrt_pkg::ITERS-1:0], mag[ssqrt_pkg::MAG_BITS-1 -: 2]};
  assign trial     = {res, 2'b01};
  assign diff      = {1'b0, rem_shift} - {1'b0, trial};

  // Next state and status
  always_comb begin
    state_next  = state;
    status.idle = 1'b0;
    status.done = 1'b0;
    case (state)
      ssqrt_pkg::ST_IDLE: begin
        status.idle = 1'b1;
        if (ctrl.start) begin
          state_next = ssqrt_pkg::ST_RUN;
        end
      end
      ssqrt_pkg::ST_RUN: begin
        if (count == '0) begin
          state_next = ssqrt_pkg::ST_DONE;
        end
      end
      ssqrt_pkg::ST_DONE: begin
        status.done = 1'b1;
        if (ctrl.ack) begin
          state_next = ssqrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ssqrt_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssqrt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: load on start, advance one root bit per cycle while running
  always_ff @(posedge clk) begin
    if (state == ssqrt_pkg::ST_IDLE && ctrl.start) begin
      mag   <= ssqrt_pkg::MAG_BITS'(op_mag);
      neg   <= op_raw[ssqrt_pkg::OPERAND_BITS-1];
      rem   <= '0;
      res   <= '0;
      count <= ssqrt_pkg::CNT_BITS'(ssqrt_pkg::ITERS - 1);
    end else if (state == ssqrt_pkg::ST_RUN) begin
      mag   <= {mag[ssqrt_pkg::MAG_BITS-3:0], 2'b00};
      count <= count - 1'b1;
      if (!diff[ssqrt_pkg::REM_BITS]) begin
        rem <= diff[ssqrt_pkg::REM_BITS-1:0];
        res <= {res[ssqrt_pkg::ITERS-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        res <= {res[ssqrt_pkg::ITERS-2:0], 1'b0};
      end
    end
  end

  // Apply the operand's sign to the root
  assign res_ext = ssqrt_pkg::ROOT_BITS'(res);
  assign root    = neg ? (~res_ext + 1'b1) : res_ext;

endmodule

// ===== design/signed_integer_square_root.sv =====
// Top level of the signed integer square root block: stream handshake and result register.
// Depends on ssqrt_pkg and ssqrt_core.
//
// Channel  Dir  Payload (tdata, low bit first)          Handshake
// s_*      in   operand[63:0]                            s_tvalid / s_tready
// m_*      out  root[32:0] signed, bits 39:33 zero        m_tvalid / m_tready
//
// An operand taken on the accepting edge is loaded into the root unit; 32 steps of the
// shared subtract-and-compare follow, then the root unit hands the root over to the result
// register. The next operand is taken only after the root unit has handed its root over.
// s_tready is high only while the root unit is idle; a new operand is taken while an
// earlier result still waits in the output register.
// A stalled output holds the finished root inside the root unit until the register frees.
// rst (synchronous, active high) clears the sequencer and the output valid flag.
module signed_integer_square_root (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [ssqrt_pkg::IN_TDATA_BITS-1:0]   s_tdata,   // operand[63:0]
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [ssqrt_pkg::OUT_TDATA_BITS-1:0]  m_tdata    // root[32:0], zero pad above
);

  ssqrt_pkg::core_ctrl_t   ctrl;
  ssqrt_pkg::core_status_t status;
  logic [ssqrt_pkg::ROOT_BITS-1:0] core_root;
  logic [ssqrt_pkg::ROOT_BITS-1:0] root_q;
  logic                            load;

  // Accept a request whenever the root unit is idle
  assign s_tready   = status.idle;
  assign ctrl.start = s_tvalid & s_tready;

  // Move the finished root into the output register when it is free
  assign load     = status.done & (~m_tvalid | m_tready);
  assign ctrl.ack = load;

  ssqrt_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .operand (s_tdata),
    .status  (status),
    .root    (core_root)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      root_q <= core_root;
    end
  end

  assign m_tdata = ssqrt_pkg::OUT_TDATA_BITS'(root_q);

  // An accepted request makes the unit busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("root unit still ready after accepting a request");

  // A new result appears only from a finished root
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(status.done))
    else $error("output valid without a finished root");

  // The root unit never reports idle and done at once
  a_idle_done_excl: assert property (@(posedge clk) disable iff (rst)
    !(status.idle && status.done))
    else $error("root unit idle and done together");

endmodule

// ===== tb/signed_integer_square_root_tb.sv =====
// Testbench for signed_integer_square_root: streams signed 64-bit operands and checks each root.
// Depends on ssqrt_pkg and the signed_integer_square_root RTL; self-contained otherwise.
`timescale 1ns / 1ps

module signed_integer_square_root_tb;

  localparam int RANDOM_ITEMS = 1050;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  // One directed row: operand, whether the root is typed in, and that root
  typedef struct packed {
    logic [ssqrt_pkg::IN_TDATA_BITS-1:0] operand;
    logic                                typed;
    logic [ssqrt_pkg::ROOT_BITS-1:0]     root;
  } stim_row_t;

  // One outstanding root, kept with its operand for reporting
  typedef struct packed {
    logic [ssqrt_pkg::IN_TDATA_BITS-1:0] operand;
    logic [ssqrt_pkg::ROOT_BITS-1:0]     root;
  } pending_root_t;

  logic                                 clk      = 1'b0;
  logic                                 rst      = 1'b1;
  logic                                 s_tvalid = 1'b0;
  logic                                 s_tready;
  logic [ssqrt_pkg::IN_TDATA_BITS-1:0]  s_tdata  = '0;   // operand[63:0]
  logic                                 m_tvalid;
  logic                                 m_tready = 1'b0;
  logic [ssqrt_pkg::OUT_TDATA_BITS-1:0] m_tdata;         // root[32:0], zero pad above

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int errors         = 0;
  int quiet_cycles   = 0;

  pending_root_t pending_roots[$];
  stim_row_t     dir_rows[$];

  signed_integer_square_root u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Floor root of the magnitude, settled one root bit at a time from the top,
  // then given the operand's sign. The most negative operand negates to 2^63 unsigned.
  function automatic logic [ssqrt_pkg::ROOT_BITS-1:0] predict_root(
    input logic [ssqrt_pkg::IN_TDATA_BITS-1:0] operand);
    logic [63:0] magnitude;
    logic [63:0] trial;
    logic [63:0] root;
    root      = '0;
    magnitude = operand[63] ? -operand : operand;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= magnitude)
        root = trial;
    end
    return operand[63] ? -root[ssqrt_pkg::ROOT_BITS-1:0] : root[ssqrt_pkg::ROOT_BITS-1:0];
  endfunction

  // Draw an operand: full range, near a perfect square, random magnitude width, or small
  function automatic logic [ssqrt_pkg::IN_TDATA_BITS-1:0] random_operand();
    logic [63:0] value;
    logic [63:0] base;
    int          mode;
    mode = $urandom_range(3);
    case (mode)
      0: value = {$urandom, $urandom};
      1: begin
        base  = $urandom_range(32'd3037000499, 0);
        value = base * base - 64'd1 + $urandom_range(2);
      end
      2: value = {$urandom, $urandom} >> $urandom_range(63);
      default: value = $urandom_range(1000);
    endcase
    if (mode != 0 && $urandom_range(1) == 1)
      value = -value;
    return value;
  endfunction

  // Offer one request, idling first at random; record the expected root on acceptance
  task automatic offer_request(input logic [ssqrt_pkg::IN_TDATA_BITS-1:0] operand,
                               input logic typed,
                               input logic [ssqrt_pkg::ROOT_BITS-1:0] root);
    pending_root_t item;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= operand;
    do @(posedge clk); while (!s_tready);
    item.operand = operand;
    item.root    = typed ? root : predict_root(operand);
    pending_roots.push_back(item);
    @(negedge clk);
  endtask

  // Stall the result side at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each accepted root with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_roots.size() == 0) begin
        errors++;
        $display("%0t: unexpected root: expected none, got %0d", $time,
                 $signed(m_tdata[ssqrt_pkg::ROOT_BITS-1:0]));
      end else begin
        if (m_tdata[ssqrt_pkg::ROOT_BITS-1:0] !== pending_roots[0].root) begin
          errors++;
          $display("%0t: root mismatch for operand %h: expected %0d, got %0d", $time,
                   pending_roots[0].operand, $signed(pending_roots[0].root),
                   $signed(m_tdata[ssqrt_pkg::ROOT_BITS-1:0]));
        end
        void'(pending_roots.pop_front());
      end
    end
  end

  // Abort when neither side has moved for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Directed rows: trivial roots, sign handling, both extremes, powers and squares
    dir_rows.push_back({64'd0, 1'b1, 33'd0});
    dir_rows.push_back({64'd1, 1'b1, 33'd1});
    dir_rows.push_back({64'hFFFF_FFFF_FFFF_FFFF, 1'b1, -33'sd1});
    dir_rows.push_back({64'd2, 1'b1, 33'd1});
    dir_rows.push_back({64'd3, 1'b1, 33'd1});
    dir_rows.push_back({64'd4, 1'b1, 33'd2});
    dir_rows.push_back({-64'sd4, 1'b1, -33'sd2});
    dir_rows.push_back({-64'sd2, 1'b1, -33'sd1});
    dir_rows.push_back({64'd16, 1'b1, 33'd4});
    dir_rows.push_back({64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 33'd3037000499});
    dir_rows.push_back({64'h8000_0000_0000_0000, 1'b1, -33'sd3037000499});
    dir_rows.push_back({64'h4000_0000_0000_0000, 1'b1, 33'd2147483648});
    dir_rows.push_back({64'hC000_0000_0000_0000, 1'b1, -33'sd2147483648});
    dir_rows.push_back({64'd15, 1'b0, 33'd0});
    dir_rows.push_back({64'd24, 1'b0, 33'd0});
    dir_rows.push_back({64'd25, 1'b0, 33'd0});
    dir_rows.push_back({-64'sd99, 1'b0, 33'd0});
    dir_rows.push_back({64'd3037000499 * 64'd3037000499, 1'b0, 33'd0});
    dir_rows.push_back({64'd3037000499 * 64'd3037000499 - 64'd1, 1'b0, 33'd0});
    dir_rows.push_back({64'd3037000499 * 64'd3037000499 + 64'd1, 1'b0, 33'd0});
    dir_rows.push_back({-(64'd3037000499 * 64'd3037000499), 1'b0, 33'd0});
    dir_rows.push_back({64'h8000_0000_0000_0001, 1'b0, 33'd0});
    dir_rows.push_back({64'h5555_5555_5555_5555, 1'b0, 33'd0});
    dir_rows.push_back({64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 33'd0});

    // Hold reset, then release at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      offer_request(dir_rows[i].operand, dir_rows[i].typed, dir_rows[i].root);

    // Random operands across the idling phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case (n * 4 / RANDOM_ITEMS)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 46;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 46;
        end
        default: begin
          src_idle_pct   = 23;
          sink_stall_pct = 23;
        end
      endcase
      offer_request(random_operand(), 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    // Drain outstanding roots, then let the pipeline settle
    while (pending_roots.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
